// ===== hdl/cubic_trajectory_generator_unit_macros.svh =====
// Assertion macros for the cubic trajectory generator
`ifndef CUBIC_TRAJECTORY_GENERATOR_UNIT_MACROS_SVH
`define CUBIC_TRAJECTORY_GENERATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CTG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CTG_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/ctg_pkg.sv =====
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared types, codes and saturation limits of the trajectory generator.
// ----------------------------------------------------------------------------
package ctg_pkg;
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SATURATED = 2'd1;
   localparam logic [1:0] STATUS_ZERO_TIME = 2'd2;

   localparam logic OP_PLAN     = 1'b0;
   localparam logic OP_EVALUATE = 1'b1;

   localparam logic signed [47:0] MAX48 = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] MIN48 = {1'b1, {47{1'b0}}};

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_LOAD     = 4'd1;  // capture the input word
   localparam logic [3:0] CMD_DIV_3D   = 4'd2;  // start div(3D)
   localparam logic [3:0] CMD_DIV_A2   = 4'd3;  // start div(q - (2v0+vf))
   localparam logic [3:0] CMD_DIV_M2D  = 4'd4;  // start div(-2D), save a2
   localparam logic [3:0] CMD_DIV_B1   = 4'd5;  // start div(q + v0 + vf)
   localparam logic [3:0] CMD_DIV_B2   = 4'd6;  // start div(q)
   localparam logic [3:0] CMD_STORE    = 4'd7;  // write coefficients
   localparam logic [3:0] CMD_RD_A3    = 4'd8;
   localparam logic [3:0] CMD_MUL_A3   = 4'd9;
   localparam logic [3:0] CMD_MUL_S1   = 4'd10;
   localparam logic [3:0] CMD_MUL_S2   = 4'd11;
   localparam logic [3:0] CMD_FINISH   = 4'd12; // build the result word
   localparam logic [3:0] CMD_ACC_A2   = 4'd13;
   localparam logic [3:0] CMD_ACC_A1   = 4'd14;

   typedef struct packed {
      logic [3:0] cmd;
   } ctg_ctrl_type;

   typedef struct packed {
      logic div_busy;
      logic mul_busy;
      logic operation;
      logic zero_time;
      logic sel_valid;
   } ctg_stat_type;

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'(MAX48)) begin
         return MAX48;
      end else if (v < 50'(MIN48)) begin
         return MIN48;
      end
      return v[47:0];
   endfunction

   function automatic logic ovf48(input logic signed [49:0] v);
      return (v > 50'(MAX48)) || (v < 50'(MIN48));
   endfunction
endpackage

// ===== hdl/ctg_divider.sv =====
// ----------------------------------------------------------------------------
// ctg_divider
// Radix-2 restoring divider: sat48(x) * 2^16 / t, rounded half away from zero.
// ----------------------------------------------------------------------------
module ctg_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [49:0]  dividend,
   input  logic [30:0]         divisor,
   output logic                busy,
   output logic                done,
   output logic signed [47:0]  quotient,
   output logic                sat
);
   localparam logic [48:0] MAXP1 = 49'h1_0000_0000_0000 >> 1;

   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [30:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        sat_ff, sat_in;
   logic        done_ff, done_in;

   logic signed [47:0] s48;
   logic [47:0]        mag;
   logic [32:0]        trial;
   logic [64:0]        q_round;

   always_comb begin
      s48 = ctg_pkg::sat48(dividend);
      mag = s48[47] ? 48'(-s48) : 48'(s48);
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; sat_in = sat_ff;
      done_in = 1'b0;
      trial = {rem_ff, num_ff[63]} - {2'b0, den_ff};
      if (start) begin
         num_in  = {mag, 16'd0};
         rem_in  = '0;
         quo_in  = '0;
         den_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
         neg_in  = s48[47];
         sat_in  = ctg_pkg::ovf48(dividend);
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder
         num_in = {num_ff[62:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], num_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // round: q+1 when 2*rem >= t (equals floor((m+floor(t/2))/t))
   always_comb begin
      q_round = {1'b0, quo_ff};
      if ({rem_ff, 1'b0} >= {2'b0, den_ff}) begin
         q_round = q_round + 65'd1;
      end
   end

   logic signed [49:0] qs;
   always_comb begin
      if (q_round > 65'(MAXP1)) begin
         qs = neg_ff ? 50'(ctg_pkg::MIN48) : 50'(ctg_pkg::MAX48) + 50'd1;
      end else begin
         qs = neg_ff ? -50'(q_round[48:0]) : 50'(q_round[48:0]);
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = ctg_pkg::sat48(qs);
   assign sat      = sat_ff | ctg_pkg::ovf48(qs);

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; sat_ff <= sat_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

// ===== hdl/ctg_datapath.sv =====
// ----------------------------------------------------------------------------
// ctg_datapath
// Operand registers, shared divider, Q16.16 multiplier and coefficient store.
// ----------------------------------------------------------------------------
module ctg_datapath #(
   parameter int NUM_LEGS = 2,
   parameter int NUM_AXES = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctg_pkg::ctg_ctrl_type ctrl,
   output ctg_pkg::ctg_stat_type stat,
   input  logic [162:0]          in_word,
   output logic [39:0]           out_word
);
   localparam int SLOTS = NUM_LEGS * NUM_AXES;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic        op_ff;
   logic [0:0]  leg_ff;
   logic [1:0]  axis_ff;
   logic signed [31:0] p0_ff, v0_ff, pf_ff, vf_ff;
   logic [30:0] t_ff;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] a2_ff;
   logic        sat_ff, sat_in;
   logic [39:0] out_ff;

   logic signed [47:0] coef_ff [SLOTS][4];
   logic [SLOTS-1:0]   written_ff;

   logic sel_valid;
   logic [SW-1:0] slot;
   assign sel_valid = (32'(leg_ff) < 32'(NUM_LEGS)) && (32'(axis_ff) < 32'(NUM_AXES));
   assign slot = SW'(32'(leg_ff) * 32'(NUM_AXES) + 32'(axis_ff));

   function automatic logic signed [47:0] rd(input logic [SW-1:0] s, input int k,
                                             input logic [SLOTS-1:0] w,
                                             input logic signed [47:0] c [SLOTS][4]);
      return w[s] ? c[s][k] : '0;
   endfunction

   // divider operands
   logic signed [33:0] d_w;
   logic               div_start, div_done, div_busy, div_sat;
   logic signed [49:0] div_x;
   logic signed [47:0] div_q;

   assign d_w = 34'(pf_ff) - 34'(p0_ff);

   always_comb begin
      div_start = 1'b0;
      div_x = '0;
      unique case (ctrl.cmd)
         ctg_pkg::CMD_DIV_3D: begin
            div_start = 1'b1; div_x = 50'(d_w) * 50'sd3;
         end
         ctg_pkg::CMD_DIV_A2: begin
            div_start = 1'b1;
            div_x = 50'(acc_ff) - (50'(v0_ff) * 50'sd2 + 50'(vf_ff));
         end
         ctg_pkg::CMD_DIV_M2D: begin
            div_start = 1'b1; div_x = 50'(d_w) * -50'sd2;
         end
         ctg_pkg::CMD_DIV_B1: begin
            div_start = 1'b1; div_x = 50'(acc_ff) + 50'(v0_ff) + 50'(vf_ff);
         end
         ctg_pkg::CMD_DIV_B2: begin
            div_start = 1'b1; div_x = 50'(acc_ff);
         end
         default: ;
      endcase
   end

   ctg_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_x),
      .divisor(t_ff), .busy(div_busy), .done(div_done), .quotient(div_q), .sat(div_sat)
   );

   // multiplier: |a|*t over two registered stages, hi and lo partial products
   logic [47:0] m_mag;
   logic        m_neg_ff, m_neg1_ff;
   logic [63:0] hi_ff;
   logic [47:0] lo_ff;
   logic [1:0]  mstage_ff, mstage_in;
   logic [63:0] mp;
   logic [48:0] mclip;
   logic signed [49:0] mres;
   logic mul_go;
   assign mul_go = (ctrl.cmd == ctg_pkg::CMD_MUL_A3) || (ctrl.cmd == ctg_pkg::CMD_MUL_S1)
                   || (ctrl.cmd == ctg_pkg::CMD_MUL_S2);
   assign m_mag = acc_ff[47] ? 48'(-acc_ff) : 48'(acc_ff);
   assign mp = hi_ff + 64'((lo_ff + 48'h8000) >> 16);
   // clip huge products to 2^48; the sum with any addend still saturates the same way
   assign mclip = (mp > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : mp[48:0];
   assign mres = m_neg1_ff ? -50'(mclip) : 50'(mclip);

   always_comb begin
      mstage_in = mul_go ? 2'd1 : (mstage_ff == 2'd1 ? 2'd2 : 2'd0);
   end

   logic signed [49:0] sum_w;
   logic signed [47:0] addend;
   always_comb begin
      addend = '0;
      unique case (ctrl.cmd)
         ctg_pkg::CMD_ACC_A2: addend = rd(slot, 2, written_ff, coef_ff);
         ctg_pkg::CMD_ACC_A1: addend = rd(slot, 1, written_ff, coef_ff);
         default:             addend = rd(slot, 0, written_ff, coef_ff);
      endcase
      sum_w = mres + 50'(addend);
   end

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (ctrl.cmd == ctg_pkg::CMD_LOAD) begin
         sat_in = 1'b0;
      end
      if (div_done) begin
         acc_in = div_q;
         sat_in = sat_in | div_sat;
      end
      unique case (ctrl.cmd)
         ctg_pkg::CMD_RD_A3: acc_in = rd(slot, 3, written_ff, coef_ff);
         ctg_pkg::CMD_ACC_A2, ctg_pkg::CMD_ACC_A1: begin
            acc_in = ctg_pkg::sat48(sum_w);
            sat_in = sat_ff | ctg_pkg::ovf48(sum_w);
         end
         default: ;
      endcase
   end

   logic signed [31:0] pos_w;
   logic               psat;
   always_comb begin
      psat = (sum_w > 50'sd2147483647) || (sum_w < -50'sd2147483648);
      if (sum_w > 50'sd2147483647) begin
         pos_w = 32'sh7FFFFFFF;
      end else if (sum_w < -50'sd2147483648) begin
         pos_w = 32'sh80000000;
      end else begin
         pos_w = sum_w[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cmd == ctg_pkg::CMD_LOAD) begin
         op_ff   <= in_word[0];
         leg_ff  <= in_word[1];
         axis_ff <= in_word[3:2];
         p0_ff   <= in_word[35:4];
         v0_ff   <= in_word[67:36];
         pf_ff   <= in_word[99:68];
         vf_ff   <= in_word[131:100];
         t_ff    <= in_word[162:132];
      end
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      if (ctrl.cmd == ctg_pkg::CMD_DIV_M2D) a2_ff <= acc_ff;
      if (mul_go) begin
         m_neg_ff <= acc_ff[47];
         hi_ff    <= 64'(m_mag >> 16) * 64'(t_ff);
         lo_ff    <= 48'(m_mag[15:0]) * 48'(t_ff);
      end
      m_neg1_ff <= m_neg_ff;
      if (ctrl.cmd == ctg_pkg::CMD_STORE && sel_valid) begin
         coef_ff[slot][0] <= 48'(p0_ff);
         coef_ff[slot][1] <= 48'(v0_ff);
         coef_ff[slot][2] <= a2_ff;
         coef_ff[slot][3] <= acc_ff;
      end
      if (ctrl.cmd == ctg_pkg::CMD_FINISH) begin
         if (op_ff == ctg_pkg::OP_PLAN) begin
            out_ff <= {6'd0, (t_ff == '0) ? ctg_pkg::STATUS_ZERO_TIME :
                       ((sel_valid && sat_ff) ? ctg_pkg::STATUS_SATURATED :
                        ctg_pkg::STATUS_OK), p0_ff};
         end else if (!sel_valid) begin
            out_ff <= {6'd0, ctg_pkg::STATUS_OK, 32'd0};
         end else begin
            out_ff <= {6'd0, (sat_ff || psat) ? ctg_pkg::STATUS_SATURATED :
                       ctg_pkg::STATUS_OK, pos_w};
         end
      end
      if (reset) begin
         mstage_ff  <= 2'd0;
         written_ff <= '0;
      end else begin
         mstage_ff <= mstage_in;
         if (ctrl.cmd == ctg_pkg::CMD_STORE && sel_valid) written_ff[slot] <= 1'b1;
      end
   end

   assign stat.div_busy  = div_busy | div_start;
   assign stat.mul_busy  = mul_go | (mstage_ff != 2'd0);
   assign stat.operation = op_ff;
   assign stat.zero_time = (t_ff == '0);
   assign stat.sel_valid = sel_valid;
   assign out_word = out_ff;
endmodule

// ===== hdl/ctg_controller.sv =====
// ----------------------------------------------------------------------------
// ctg_controller
// Sequencer for plan and evaluate; drives at most one datapath command at a time.
// ----------------------------------------------------------------------------
`include "cubic_trajectory_generator_unit_macros.svh"
module ctg_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ctg_pkg::ctg_ctrl_type ctrl,
   input  ctg_pkg::ctg_stat_type stat
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_D1 = 4'd2;
   localparam logic [3:0] S_D2 = 4'd3;
   localparam logic [3:0] S_D3 = 4'd4;
   localparam logic [3:0] S_D4 = 4'd5;
   localparam logic [3:0] S_D5 = 4'd6;
   localparam logic [3:0] S_STORE = 4'd7;
   localparam logic [3:0] S_M1 = 4'd8;
   localparam logic [3:0] S_M2 = 4'd9;
   localparam logic [3:0] S_M3 = 4'd10;
   localparam logic [3:0] S_FIN = 4'd11;
   localparam logic [3:0] S_RD = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic       started_ff, started_in;

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      started_in = started_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      ctrl.cmd = ctg_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            ctrl.cmd = ctg_pkg::CMD_LOAD;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.operation == ctg_pkg::OP_EVALUATE) begin
               state_in = S_RD;
            end else if (stat.zero_time || !stat.sel_valid) begin
               state_in = S_FIN;
            end else begin
               state_in = S_D1; started_in = 1'b0;
            end
         end
         S_D1, S_D2, S_D3, S_D4, S_D5: begin
            if (!started_ff) begin
               started_in = 1'b1;
               unique case (state_ff)
                  S_D1: ctrl.cmd = ctg_pkg::CMD_DIV_3D;
                  S_D2: ctrl.cmd = ctg_pkg::CMD_DIV_A2;
                  S_D3: ctrl.cmd = ctg_pkg::CMD_DIV_M2D;
                  S_D4: ctrl.cmd = ctg_pkg::CMD_DIV_B1;
                  default: ctrl.cmd = ctg_pkg::CMD_DIV_B2;
               endcase
            end else if (!stat.div_busy) begin
               started_in = 1'b0;
               state_in = (state_ff == S_D5) ? S_STORE : state_ff + 4'd1;
            end
         end
         S_STORE: begin
            ctrl.cmd = ctg_pkg::CMD_STORE;
            state_in = S_FIN;
         end
         S_RD: begin
            ctrl.cmd = ctg_pkg::CMD_RD_A3;
            state_in = S_M1; started_in = 1'b0;
         end
         S_M1, S_M2, S_M3: begin
            if (!started_ff) begin
               started_in = 1'b1;
               step_in = 2'd0;
               ctrl.cmd = (state_ff == S_M1) ? ctg_pkg::CMD_MUL_A3 :
                          (state_ff == S_M2) ? ctg_pkg::CMD_MUL_S1 : ctg_pkg::CMD_MUL_S2;
            end else if (step_ff != 2'd1) begin
               step_in = step_ff + 2'd1;
            end else begin
               started_in = 1'b0;
               unique case (state_ff)
                  S_M1: begin ctrl.cmd = ctg_pkg::CMD_ACC_A2; state_in = S_M2; end
                  S_M2: begin ctrl.cmd = ctg_pkg::CMD_ACC_A1; state_in = S_M3; end
                  default: begin ctrl.cmd = ctg_pkg::CMD_FINISH; state_in = S_IDLE;
                     out_valid_in = 1'b1; end
               endcase
            end
         end
         S_FIN: begin
            ctrl.cmd = ctg_pkg::CMD_FINISH;
            out_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 2'd0;
         out_valid_ff <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         out_valid_ff <= out_valid_in;
         started_ff <= started_in;
      end
   end

   `CTG_ASSERT_IMPL(a_ready_idle, clock, reset, req_tready, state_ff == S_IDLE,
                    "ready outside idle")
   `CTG_ASSERT_NEXT(a_hold_rsp, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
                    "result dropped")
   `CTG_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready,
                    "accept while result pending")
endmodule

// ===== hdl/cubic_trajectory_generator_unit.sv =====
// Steps up to rsp_tvalid: plan = decode, five divides, store, finish; evaluate = decode,
// a3 read, three multiply steps; zero-duration or unmapped plan = decode, finish.
// Throughput: one word in flight; req_tready returns the cycle after the result is taken.
// Reset: synchronous, active high; clears control and marks all coefficients zero.
// ----------------------------------------------------------------------------
// cubic_trajectory_generator_unit
// Cubic point-to-point planner and evaluator over per-leg, per-axis coefficients.
// ----------------------------------------------------------------------------
module cubic_trajectory_generator_unit #(
   parameter int NUM_LEGS = 2,
   parameter int NUM_AXES = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation, leg_select, axis_select[1:0], start_position, start_velocity,
   // end_position, end_velocity, time_value[30:0], zero pad
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // position_out[31:0], status[1:0], zero pad
   output logic [39:0]  rsp_tdata
);
   ctg_pkg::ctg_ctrl_type ctrl;
   ctg_pkg::ctg_stat_type stat;

   ctg_controller u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .ctrl(ctrl), .stat(stat)
   );

   ctg_datapath #(.NUM_LEGS(NUM_LEGS), .NUM_AXES(NUM_AXES)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .in_word(req_tdata[162:0]), .out_word(rsp_tdata)
   );
endmodule
